// ===== rtl/core/sts_pkg.sv =====
`default_nettype none
package sts_pkg;

  localparam int POS_BITS   = 32;
  localparam int NAME_CHARS = 6;
  localparam int NLEN_BITS  = $clog2(NAME_CHARS + 2);
  localparam int NIDX_BITS  = $clog2(NAME_CHARS);
  localparam int QDEPTH     = 4;
  localparam int QIDX_BITS  = $clog2(QDEPTH);

  localparam logic [POS_BITS-1:0] POS_TOP  = {POS_BITS{1'b1}};
  localparam logic [31:0]         LINE_TOP = 32'hFFFF_FFFF;

  // token kinds
  localparam logic [5:0] K_LPAREN   = 6'd0;
  localparam logic [5:0] K_RPAREN   = 6'd1;
  localparam logic [5:0] K_LBRACE   = 6'd2;
  localparam logic [5:0] K_RBRACE   = 6'd3;
  localparam logic [5:0] K_SEMI     = 6'd4;
  localparam logic [5:0] K_COMMA    = 6'd5;
  localparam logic [5:0] K_DOT      = 6'd6;
  localparam logic [5:0] K_MINUS    = 6'd7;
  localparam logic [5:0] K_PLUS     = 6'd8;
  localparam logic [5:0] K_SLASH    = 6'd9;
  localparam logic [5:0] K_STAR     = 6'd10;
  localparam logic [5:0] K_BANG     = 6'd11;
  localparam logic [5:0] K_EQUAL    = 6'd13;
  localparam logic [5:0] K_LESS     = 6'd15;
  localparam logic [5:0] K_GREATER  = 6'd17;
  localparam logic [5:0] K_IDENT    = 6'd19;
  localparam logic [5:0] K_STRING   = 6'd20;
  localparam logic [5:0] K_NUMBER   = 6'd21;
  localparam logic [5:0] K_KEYWORD0 = 6'd22;
  localparam logic [5:0] K_ERROR    = 6'd37;
  localparam logic [5:0] K_EOF      = 6'd38;

  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_UNEXP    = 2'd1;
  localparam logic [1:0] E_UNTERM   = 2'd2;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_COMMENT, M_IDENT, M_NUMBER, M_NUMDOT, M_FRAC,
    M_STRING, M_BANG, M_EQUAL, M_LESS, M_GREATER
  } mode_t;

  // one pending token slot, as the front classifies it
  typedef struct packed {
    logic [5:0]          kind;
    logic [1:0]          err;
    logic [POS_BITS-1:0] start;
    logic [POS_BITS-1:0] len;
    logic [31:0]         line;
  } tok_t;

  // a classified transaction: up to three tokens
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
    tok_t       t2;
  } batch_t;

  typedef logic [7:0] name_t [NAME_CHARS];

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [31:0] clip32(input logic [POS_BITS-1:0] v);
    logic [31:0] r;
    if (POS_BITS > 32) begin
      r = (v > POS_BITS'(LINE_TOP)) ? LINE_TOP : 32'(v);
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  // keyword lookup over the buffered name prefix
  function automatic logic [5:0] kw_kind(input name_t p,
                                         input logic [NLEN_BITS-1:0] n);
    logic [47:0] w;
    logic [5:0]  k;
    w = '0;
    for (int i = 0; i < 6; i++) begin
      if (i < NAME_CHARS && i < int'(n)) w[47-8*i -: 8] = p[i];
    end
    k = K_IDENT;
    case (n)
      NLEN_BITS'(2): begin
        if (w[47:32] == "if") k = K_KEYWORD0 + 6'd6;
        else if (w[47:32] == "or") k = K_KEYWORD0 + 6'd8;
      end
      NLEN_BITS'(3): begin
        if (w[47:24] == "and") k = K_KEYWORD0 + 6'd0;
        else if (w[47:24] == "for") k = K_KEYWORD0 + 6'd4;
        else if (w[47:24] == "fun") k = K_KEYWORD0 + 6'd5;
        else if (w[47:24] == "nil") k = K_KEYWORD0 + 6'd7;
      end
      NLEN_BITS'(4): begin
        if (w[47:16] == "else") k = K_KEYWORD0 + 6'd2;
        else if (w[47:16] == "this") k = K_KEYWORD0 + 6'd12;
        else if (w[47:16] == "true") k = K_KEYWORD0 + 6'd13;
      end
      NLEN_BITS'(5): begin
        if (w[47:8] == "class") k = K_KEYWORD0 + 6'd1;
        else if (w[47:8] == "false") k = K_KEYWORD0 + 6'd3;
        else if (w[47:8] == "print") k = K_KEYWORD0 + 6'd9;
        else if (w[47:8] == "super") k = K_KEYWORD0 + 6'd11;
        else if (w[47:8] == "while") k = K_KEYWORD0 + 6'd14;
      end
      NLEN_BITS'(6): begin
        if (w == "return") k = K_KEYWORD0 + 6'd10;
      end
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sts_front.sv =====
`default_nettype none
module sts_front import sts_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_end_marker,
  output logic            b_valid,
  output batch_t          b_data,
  input  wire logic       b_full
);

  mode_t                  mode_r, mode_nxt;
  logic [POS_BITS-1:0]    tstart_r, tstart_nxt;
  logic [POS_BITS-1:0]    pos_r, pos_nxt;
  logic [31:0]            line_r, line_nxt;
  name_t                  name_r;
  logic [NLEN_BITS-1:0]   nlen_r, nlen_nxt;
  logic                   nwr;
  logic [NIDX_BITS-1:0]   nwr_idx;

  logic                   acc;
  logic [POS_BITS-1:0]    len, dot, sstart;
  tok_t                   toks [3];
  logic [1:0]             n;
  logic [5:0]             opk;
  logic [7:0]             c;

  assign in_stall = b_full;
  assign acc      = in_valid && !b_full;
  assign c        = in_char_byte;

  assign len    = (pos_r > tstart_r) ? pos_r - tstart_r : '0;
  assign dot    = (pos_r > tstart_r) ? pos_r - POS_BITS'(1) : tstart_r;
  assign sstart = (tstart_r < POS_TOP) ? tstart_r + POS_BITS'(1) : tstart_r;

  always_comb begin
    case (mode_r)
      M_BANG:  opk = K_BANG;
      M_EQUAL: opk = K_EQUAL;
      M_LESS:  opk = K_LESS;
      default: opk = K_GREATER;
    endcase
  end

  // classify one transaction into up to three tokens and the next state
  always_comb begin
    logic        do_idle;
    logic [31:0] ln;
    logic [31:0] ln_up;
    mode_t       im;
    logic        itok;
    logic [5:0]  ik;
    logic [1:0]  ie;
    logic        istart;
    do_idle  = 1'b0;
    ln       = line_r;
    ln_up    = (line_r < LINE_TOP) ? line_r + 32'd1 : line_r;
    im       = M_IDLE;
    itok     = 1'b0;
    ik       = K_ERROR;
    ie       = E_NONE;
    istart   = 1'b0;
    n        = 2'd0;
    for (int i = 0; i < 3; i++) toks[i] = '0;
    mode_nxt   = mode_r;
    tstart_nxt = tstart_r;
    nlen_nxt   = nlen_r;
    nwr        = 1'b0;
    nwr_idx    = '0;
    line_nxt   = line_r;
    pos_nxt    = (pos_r < POS_TOP) ? pos_r + POS_BITS'(1) : pos_r;

    if (in_end_marker) begin
      pos_nxt = '0;
      case (mode_r)
        M_SLASH: begin
          toks[0] = '{K_SLASH, E_NONE, tstart_r, POS_BITS'(1), line_r}; n = 2'd1;
        end
        M_IDENT: begin
          toks[0] = '{kw_kind(name_r, nlen_r), E_NONE, tstart_r, len, line_r}; n = 2'd1;
        end
        M_NUMBER, M_FRAC: begin
          toks[0] = '{K_NUMBER, E_NONE, tstart_r, len, line_r}; n = 2'd1;
        end
        M_NUMDOT: begin
          toks[0] = '{K_NUMBER, E_NONE, tstart_r, dot - tstart_r, line_r};
          toks[1] = '{K_DOT, E_NONE, dot, POS_BITS'(1), line_r}; n = 2'd2;
        end
        M_STRING: begin
          toks[0] = '{K_ERROR, E_UNTERM, tstart_r, len, line_r}; n = 2'd1;
        end
        M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
          toks[0] = '{opk, E_NONE, tstart_r, POS_BITS'(1), line_r}; n = 2'd1;
        end
        default: n = 2'd0;
      endcase
      toks[n] = '{K_EOF, E_NONE, pos_r, '0, line_r};
      n = n + 2'd1;
      mode_nxt   = M_IDLE;
      tstart_nxt = '0;
      line_nxt   = 32'd1;
      nlen_nxt   = '0;
    end else begin
      case (mode_r)
        M_SLASH: begin
          if (c == "/") mode_nxt = M_COMMENT;
          else begin
            toks[0] = '{K_SLASH, E_NONE, tstart_r, POS_BITS'(1), line_r}; n = 2'd1;
            do_idle = 1'b1;
          end
        end
        M_COMMENT: if (c == 8'h0A) do_idle = 1'b1;
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (nlen_r < NLEN_BITS'(NAME_CHARS)) begin
              nwr = 1'b1; nwr_idx = NIDX_BITS'(nlen_r);
              nlen_nxt = nlen_r + NLEN_BITS'(1);
            end else nlen_nxt = NLEN_BITS'(NAME_CHARS + 1);
          end else begin
            toks[0] = '{kw_kind(name_r, nlen_r), E_NONE, tstart_r, len, line_r};
            n = 2'd1; do_idle = 1'b1;
          end
        end
        M_NUMBER, M_FRAC: begin
          if (is_digit(c)) mode_nxt = mode_r;
          else if (c == "." && mode_r == M_NUMBER) mode_nxt = M_NUMDOT;
          else begin
            toks[0] = '{K_NUMBER, E_NONE, tstart_r, len, line_r}; n = 2'd1;
            do_idle = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (is_digit(c)) mode_nxt = M_FRAC;
          else begin
            toks[0] = '{K_NUMBER, E_NONE, tstart_r, dot - tstart_r, line_r};
            toks[1] = '{K_DOT, E_NONE, dot, POS_BITS'(1), line_r}; n = 2'd2;
            do_idle = 1'b1;
          end
        end
        M_STRING: begin
          if (c == 8'h22) begin
            toks[0] = '{K_STRING, E_NONE, sstart,
                        (pos_r > sstart) ? pos_r - sstart : '0, line_r};
            n = 2'd1; mode_nxt = M_IDLE;
          end else if (c == 8'h0A) line_nxt = ln_up;
        end
        M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
          if (c == "=") begin
            toks[0] = '{opk + 6'd1, E_NONE, tstart_r, POS_BITS'(2), line_r};
            n = 2'd1; mode_nxt = M_IDLE;
          end else begin
            toks[0] = '{opk, E_NONE, tstart_r, POS_BITS'(1), line_r}; n = 2'd1;
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // a byte seen between tokens
      if (do_idle) begin
        case (c)
          8'h20, 8'h0D, 8'h09: im = M_IDLE;
          8'h0A: begin im = M_IDLE; ln = ln_up; end
          "(": begin itok = 1'b1; ik = K_LPAREN; end
          ")": begin itok = 1'b1; ik = K_RPAREN; end
          "{": begin itok = 1'b1; ik = K_LBRACE; end
          "}": begin itok = 1'b1; ik = K_RBRACE; end
          ";": begin itok = 1'b1; ik = K_SEMI; end
          ",": begin itok = 1'b1; ik = K_COMMA; end
          ".": begin itok = 1'b1; ik = K_DOT; end
          "-": begin itok = 1'b1; ik = K_MINUS; end
          "+": begin itok = 1'b1; ik = K_PLUS; end
          "*": begin itok = 1'b1; ik = K_STAR; end
          "/": begin im = M_SLASH; istart = 1'b1; end
          "!": begin im = M_BANG; istart = 1'b1; end
          "=": begin im = M_EQUAL; istart = 1'b1; end
          "<": begin im = M_LESS; istart = 1'b1; end
          ">": begin im = M_GREATER; istart = 1'b1; end
          8'h22: begin im = M_STRING; istart = 1'b1; end
          default: begin
            if (is_alpha(c)) begin
              im = M_IDENT; istart = 1'b1;
              nwr = 1'b1; nwr_idx = '0; nlen_nxt = NLEN_BITS'(1);
            end else if (is_digit(c)) begin
              im = M_NUMBER; istart = 1'b1;
            end else begin
              itok = 1'b1; ik = K_ERROR; ie = E_UNEXP;
            end
          end
        endcase
        mode_nxt = im;
        line_nxt = ln;
        if (istart) tstart_nxt = pos_r;
        if (itok) begin
          toks[n] = '{ik, ie, pos_r, POS_BITS'(1), line_r};
          n = n + 2'd1;
        end
      end
    end
  end

  always_comb begin
    b_valid   = acc && (n != 2'd0);
    b_data.cnt = n;
    b_data.t0  = toks[0];
    b_data.t1  = toks[1];
    b_data.t2  = toks[2];
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      tstart_r <= '0;
      pos_r    <= '0;
      line_r   <= 32'd1;
      nlen_r   <= '0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      tstart_r <= tstart_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      nlen_r   <= nlen_nxt;
    end
  end

  // name prefix buffer
  always_ff @(posedge clk) begin
    if (acc && nwr) name_r[nwr_idx] <= c;
  end

endmodule
`default_nettype wire

// ===== rtl/core/sts_queue.sv =====
`default_nettype none
module sts_queue import sts_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  batch_t    wr_data,
  output logic      full,
  output logic      rd_valid,
  output batch_t    rd_data,
  input  wire logic rd_en
);

  batch_t               mem_r [QDEPTH];
  logic [QIDX_BITS-1:0] wp_r, rp_r;
  logic [QIDX_BITS:0]   cnt_r;

  assign full     = cnt_r == (QIDX_BITS+1)'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];

  // pointer and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + QIDX_BITS'(1);
      if (rd_en) rp_r <= rp_r + QIDX_BITS'(1);
      cnt_r <= cnt_r + (QIDX_BITS+1)'(wr_en) - (QIDX_BITS+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

// ===== rtl/core/sts_back.sv =====
`default_nettype none
module sts_back import sts_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_valid,
  input  batch_t      q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic [5:0]  out_token_kind,
  output logic [1:0]  out_error_kind,
  output logic [31:0] out_start_offset,
  output logic [31:0] out_lexeme_length,
  output logic [31:0] out_line_number,
  output logic        out_last_of_run
);

  logic [1:0] idx_r;
  logic       vld_r;
  tok_t       cur;
  logic       last;
  logic       load;
  logic [5:0]  kind_r;
  logic [1:0]  err_r;
  logic [31:0] st_r, ln_r, line_r;
  logic        lst_r;

  always_comb begin
    case (idx_r)
      2'd0:    cur = q_data.t0;
      2'd1:    cur = q_data.t1;
      default: cur = q_data.t2;
    endcase
  end

  // take the next token when the output register is empty or being taken
  assign last  = (idx_r + 2'd1) == q_data.cnt;
  assign load  = q_valid && (!vld_r || !out_stall);
  assign q_pop = load && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= last ? 2'd0 : idx_r + 2'd1;
      end else if (!out_stall) begin
        vld_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= cur.kind;
      err_r  <= cur.err;
      st_r   <= clip32(cur.start);
      ln_r   <= clip32(cur.len);
      line_r <= cur.line;
      lst_r  <= last;
    end
  end

  assign out_valid         = vld_r;
  assign out_token_kind    = kind_r;
  assign out_error_kind    = err_r;
  assign out_start_offset  = st_r;
  assign out_lexeme_length = ln_r;
  assign out_line_number   = line_r;
  assign out_last_of_run   = lst_r;

endmodule
`default_nettype wire

// ===== rtl/core/script_token_scanner_top.sv =====
`default_nettype none
// Channel | Ports                                           | Role
// in      | in_valid, in_stall, in_char_byte, in_end_marker | source bytes
// out     | out_valid, out_stall, out_token_kind .. last_of_run | tokens
//
// One byte is taken every cycle while in_stall is low; each token goes
// through the batch queue and the output register. A byte that completes two
// or three tokens sends them one at a time; a four-entry batch queue absorbs
// this before in_stall rises. rst_n is synchronous; it clears the scanner
// state and the queue. in_stall is high only while the batch queue is full.
module script_token_scanner_top import sts_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_end_marker,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [5:0]      out_token_kind,
  output logic [1:0]      out_error_kind,
  output logic [31:0]     out_start_offset,
  output logic [31:0]     out_lexeme_length,
  output logic [31:0]     out_line_number,
  output logic            out_last_of_run
);

  logic   b_valid, q_full, q_valid, q_pop;
  batch_t b_data, q_data;

  sts_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_char_byte, .in_end_marker,
    .b_valid, .b_data, .b_full(q_full)
  );

  sts_queue u_queue (
    .clk, .rst_n, .wr_en(b_valid), .wr_data(b_data), .full(q_full),
    .rd_valid(q_valid), .rd_data(q_data), .rd_en(q_pop)
  );

  sts_back u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_pop,
    .out_valid, .out_stall, .out_token_kind, .out_error_kind,
    .out_start_offset, .out_lexeme_length, .out_line_number, .out_last_of_run
  );

endmodule
`default_nettype wire

// ===== tb/script_token_scanner_top_tb.sv =====
`timescale 1ns / 1ps
module script_token_scanner_top_tb;
  import sts_pkg::*;

  typedef struct {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [31:0] start;
    logic [31:0] len;
    logic [31:0] line;
    logic        last;
  } token_rec_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_byte;
  logic        in_end_marker;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_token_kind;
  logic [1:0]  out_error_kind;
  logic [31:0] out_start_offset;
  logic [31:0] out_lexeme_length;
  logic [31:0] out_line_number;
  logic        out_last_of_run;

  script_token_scanner_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_char_byte(in_char_byte), .in_end_marker(in_end_marker),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_token_kind(out_token_kind), .out_error_kind(out_error_kind),
    .out_start_offset(out_start_offset), .out_lexeme_length(out_lexeme_length),
    .out_line_number(out_line_number), .out_last_of_run(out_last_of_run)
  );

  // predictor copy of the scanner state
  mode_t       sc_mode;
  logic [31:0] sc_start;
  logic [31:0] sc_pos;
  logic [31:0] sc_line;
  logic [7:0]  sc_name [NAME_CHARS];
  int          sc_nlen;

  token_rec_t  expected_tokens [$];
  token_rec_t  step_tokens [$];
  int          fail_count;
  int          token_count;
  int          byte_count;
  int          send_idle_pct;
  int          recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [31:0] diff_floor(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a - b : 32'd0;
  endfunction

  function automatic void add_token(logic [5:0] k, logic [1:0] e,
                                    logic [31:0] s, logic [31:0] l);
    token_rec_t t;
    t.kind = k; t.err = e; t.start = s; t.len = l; t.line = sc_line; t.last = 1'b0;
    if (step_tokens.size() < 3) step_tokens.insert(step_tokens.size(), t);
  endfunction

  function automatic void scanner_clear();
    sc_mode = M_IDLE; sc_start = '0; sc_pos = '0; sc_line = 32'd1; sc_nlen = 0;
    for (int i = 0; i < NAME_CHARS; i++) sc_name[i] = '0;
  endfunction

  function automatic void name_push(logic [7:0] c);
    if (sc_nlen < NAME_CHARS) begin
      sc_name[sc_nlen] = c;
      sc_nlen++;
    end else begin
      sc_nlen = NAME_CHARS + 1;
    end
  endfunction

  // keyword match on the buffered name prefix
  function automatic logic [5:0] word_kind();
    string words [15];
    string w;
    words = '{"and", "class", "else", "false", "for", "fun", "if", "nil", "or",
              "print", "return", "super", "this", "true", "while"};
    for (int i = 0; i < 15; i++) begin
      w = words[i];
      if (w.len() == sc_nlen) begin
        bit same;
        same = 1'b1;
        for (int j = 0; j < sc_nlen; j++) if (w[j] != sc_name[j]) same = 1'b0;
        if (same) return K_KEYWORD0 + 6'(i);
      end
    end
    return K_IDENT;
  endfunction

  function automatic void ident_flush();
    add_token(word_kind(), E_NONE, sc_start, diff_floor(sc_pos, sc_start));
  endfunction

  function automatic logic [5:0] op_kind();
    case (sc_mode)
      M_BANG:  return K_BANG;
      M_EQUAL: return K_EQUAL;
      M_LESS:  return K_LESS;
      default: return K_GREATER;
    endcase
  endfunction

  function automatic void number_dot_flush();
    logic [31:0] d;
    d = (sc_pos > sc_start) ? sc_pos - 1 : sc_start;
    add_token(K_NUMBER, E_NONE, sc_start, d - sc_start);
    add_token(K_DOT, E_NONE, d, 32'd1);
  endfunction

  // a byte seen between tokens
  function automatic void between_tokens(logic [7:0] c);
    logic [31:0] at;
    at = sc_pos;
    sc_mode = M_IDLE;
    case (c)
      " ", "\r", "\t": return;
      "\n": begin
        if (sc_line != LINE_TOP) sc_line++;
        return;
      end
      "(": begin add_token(K_LPAREN, E_NONE, at, 1); return; end
      ")": begin add_token(K_RPAREN, E_NONE, at, 1); return; end
      "{": begin add_token(K_LBRACE, E_NONE, at, 1); return; end
      "}": begin add_token(K_RBRACE, E_NONE, at, 1); return; end
      ";": begin add_token(K_SEMI, E_NONE, at, 1); return; end
      ",": begin add_token(K_COMMA, E_NONE, at, 1); return; end
      ".": begin add_token(K_DOT, E_NONE, at, 1); return; end
      "-": begin add_token(K_MINUS, E_NONE, at, 1); return; end
      "+": begin add_token(K_PLUS, E_NONE, at, 1); return; end
      "*": begin add_token(K_STAR, E_NONE, at, 1); return; end
      "/": sc_mode = M_SLASH;
      "!": sc_mode = M_BANG;
      "=": sc_mode = M_EQUAL;
      "<": sc_mode = M_LESS;
      ">": sc_mode = M_GREATER;
      "\"": sc_mode = M_STRING;
      default: begin
        if (alpha_c(c)) begin
          sc_mode = M_IDENT;
          sc_nlen = 0;
          name_push(c);
        end else if (digit_c(c)) begin
          sc_mode = M_NUMBER;
        end else begin
          add_token(K_ERROR, E_UNEXP, at, 1);
          return;
        end
      end
    endcase
    sc_start = at;
  endfunction

  // expected tokens for one input transaction
  function automatic void predict_tokens(logic [7:0] c, logic eom);
    logic [31:0] len;
    logic [31:0] s;
    step_tokens.delete();
    len = diff_floor(sc_pos, sc_start);
    if (eom) begin
      case (sc_mode)
        M_SLASH: add_token(K_SLASH, E_NONE, sc_start, 1);
        M_IDENT: ident_flush();
        M_NUMBER, M_FRAC: add_token(K_NUMBER, E_NONE, sc_start, len);
        M_NUMDOT: number_dot_flush();
        M_STRING: add_token(K_ERROR, E_UNTERM, sc_start, len);
        M_BANG, M_EQUAL, M_LESS, M_GREATER: add_token(op_kind(), E_NONE, sc_start, 1);
        default: ;
      endcase
      add_token(K_EOF, E_NONE, sc_pos, 0);
      scanner_clear();
    end else begin
      case (sc_mode)
        M_SLASH: begin
          if (c == "/") sc_mode = M_COMMENT;
          else begin
            add_token(K_SLASH, E_NONE, sc_start, 1);
            between_tokens(c);
          end
        end
        M_COMMENT: if (c == "\n") between_tokens(c);
        M_IDENT: begin
          if (alpha_c(c) || digit_c(c)) name_push(c);
          else begin
            ident_flush();
            between_tokens(c);
          end
        end
        M_NUMBER, M_FRAC: begin
          if (digit_c(c)) ;
          else if (c == "." && sc_mode == M_NUMBER) sc_mode = M_NUMDOT;
          else begin
            add_token(K_NUMBER, E_NONE, sc_start, len);
            between_tokens(c);
          end
        end
        M_NUMDOT: begin
          if (digit_c(c)) sc_mode = M_FRAC;
          else begin
            number_dot_flush();
            between_tokens(c);
          end
        end
        M_STRING: begin
          if (c == "\"") begin
            s = (sc_start != POS_TOP) ? sc_start + 1 : sc_start;
            add_token(K_STRING, E_NONE, s, diff_floor(sc_pos, s));
            sc_mode = M_IDLE;
          end else if (c == "\n") begin
            if (sc_line != LINE_TOP) sc_line++;
          end
        end
        M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
          if (c == "=") begin
            add_token(op_kind() + 6'd1, E_NONE, sc_start, 2);
            sc_mode = M_IDLE;
          end else begin
            add_token(op_kind(), E_NONE, sc_start, 1);
            between_tokens(c);
          end
        end
        default: between_tokens(c);
      endcase
      if (sc_pos != POS_TOP) sc_pos++;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
  endfunction

  // send one byte or end marker; prediction is made on acceptance
  task automatic send_byte(logic [7:0] c, logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= c;
    in_end_marker <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tokens(c, eom);
    byte_count++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // compare each accepted token transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      token_rec_t e;
      if (expected_tokens.size() == 0) begin
        $error("token with no expectation: kind %0d", out_token_kind);
        fail_count++;
      end else begin
        e = expected_tokens.pop_front();
        token_count++;
        if (out_token_kind !== e.kind) begin
          $error("token_kind exp %0d got %0d", e.kind, out_token_kind);
          fail_count++;
        end
        if (out_error_kind !== e.err) begin
          $error("error_kind exp %0d got %0d", e.err, out_error_kind);
          fail_count++;
        end
        if (out_start_offset !== e.start) begin
          $error("start_offset exp %0d got %0d", e.start, out_start_offset);
          fail_count++;
        end
        if (out_lexeme_length !== e.len) begin
          $error("lexeme_length exp %0d got %0d", e.len, out_lexeme_length);
          fail_count++;
        end
        if (out_line_number !== e.line) begin
          $error("line_number exp %0d got %0d", e.line, out_line_number);
          fail_count++;
        end
        if (out_last_of_run !== e.last) begin
          $error("last_of_run exp %0d got %0d", e.last, out_last_of_run);
          fail_count++;
        end
      end
    end
  end

  // operators and every keyword, with identifiers that extend keywords
  task automatic test_operators_keywords();
    send_text("(){};,.-+*/!!=a==<=<>=>x");
    send_byte(8'h00, 1'b1);
    send_text("and class else false for fun if nil or print return super this ");
    send_text("true while returns whilex _Z9 ");
    send_byte(8'h00, 1'b1);
  endtask

  // comments, newlines, numbers, trailing dot, strings, bad bytes, flushes
  task automatic test_special_cases();
    send_text("a//c x\n12.5 3. 7.x\t\r\"s\nq\" \x01");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_text("9.");
    send_byte(8'h00, 1'b1);
    send_text("\"open");
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    send_text("/");
    send_byte(8'h00, 1'b1);
    send_text("<");
    send_byte(8'h00, 1'b1);
  endtask

  // random well-formed fragments, plus raw noise and random end markers
  task automatic test_random_source(int count);
    string frags [20];
    string f;
    frags = '{"print", "while", "return", "x1", "foo_bar", "12", "3.14", "7.", "\"hi\"",
              "\"a\nb\"", "//note\n", "==", "!=", "<=", ">=", "= ", "\n", " ", ";", "class"};
    while (count > 0) begin
      if ($urandom_range(9) < 7) begin
        f = frags[$urandom_range(19)];
        send_text(f);
        count -= f.len();
        if ($urandom_range(1)) begin
          send_byte(" ", 1'b0);
          count--;
        end
      end else begin
        send_byte(8'($urandom), 1'b0);
        count--;
      end
      if ($urandom_range(39) == 0) begin
        send_byte(8'($urandom), 1'b1);
        count--;
      end
    end
    send_byte(8'($urandom), 1'b1);
  endtask

  task automatic drain_tokens();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_byte = '0;
    in_end_marker = 1'b0;
    fail_count = 0;
    token_count = 0;
    byte_count = 0;
    send_idle_pct = 36;
    recv_idle_pct = 72;
    scanner_clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_operators_keywords();
    test_special_cases();
    test_random_source(95);
    drain_tokens();
    send_idle_pct = 72;
    recv_idle_pct = 36;
    test_random_source(95);
    drain_tokens();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_source(95);
    drain_tokens();
    $display("Covered %0d input bytes/end markers and %0d tokens over three idle patterns",
             byte_count, token_count);
    if (fail_count == 0 && expected_tokens.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sts_pkg.sv
rtl/core/sts_front.sv
rtl/core/sts_queue.sv
rtl/core/sts_back.sv
rtl/core/script_token_scanner_top.sv
tb/script_token_scanner_top_tb.sv
